>>> design/assert_macros.svh
// assertion macros used by the sequencer (nntt_ctrl)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a condition implies a consequence on the same edge
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// check that a condition implies a consequence on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> design/nntt_pkg.sv
// package with constants and types of the track table
`default_nettype none
package nntt_pkg;
    localparam int MaxTracks = 16;
    localparam int IdxW = $clog2(MaxTracks);
    localparam int CntW = $clog2(MaxTracks + 1);

    localparam logic [1:0] OUT_MATCH = 2'd0;
    localparam logic [1:0] OUT_NEW   = 2'd1;
    localparam logic [1:0] OUT_DROP  = 2'd2;
    localparam logic [1:0] OUT_FRAME = 2'd3;

    localparam logic [0:0] CMD_DET   = 1'b0;
    localparam logic [0:0] CMD_FRAME = 1'b1;

    localparam logic [0:0] REG_GATE = 1'b0;
    localparam logic [0:0] REG_DROP = 1'b1;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [16:0] vx;
        logic signed [16:0] vy;
        logic [7:0]         lost;
        logic [15:0]        id;
    } track_t;

    typedef struct packed {
        logic [0:0]  cmd;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] trk_id;
        logic [4:0]  live_count;
    } out_item_t;

    typedef struct packed {
        logic [0:0]  index;
        logic [14:0] data;
    } cfg_item_t;

    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] waddr;
        track_t          wdata;
        logic [IdxW-1:0] raddr;
    } mem_ctl_t;
endpackage
`default_nettype wire

>>> design/nntt_stream_if.sv
// valid/ready channel interface carrying one payload
`default_nettype none
interface nntt_stream_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/nearest_neighbor_track_table_top.sv
// top level of the nearest neighbor track table
// detection: each live track is read in turn; an unmatched one also goes through S_MUL,
// then S_CMP and S_OUT give the result
// end of frame: compaction, one read and at most one write per cycle on the track memory
// one item at a time; the next item is taken the cycle after the result transaction
// async reset clears track count, matched flags, next id (1) and registers to defaults
`default_nettype none
module nearest_neighbor_track_table_top (
    input  wire logic clk,
    input  wire logic rst_n,
    nntt_stream_if.sink   in_ch,
    nntt_stream_if.source out_ch,
    nntt_stream_if.sink   cfg_ch
);
    import nntt_pkg::*;
    mem_ctl_t mem_ctl;
    track_t   rdata;

    nntt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_data(cfg_ch.data),
        .mem_ctl(mem_ctl), .rdata(rdata)
    );

    nntt_track_ram u_ram (
        .clk(clk), .ctl(mem_ctl), .rdata(rdata)
    );
endmodule
`default_nettype wire

>>> design/nntt_track_ram.sv
// track record memory with registered read
`default_nettype none
module nntt_track_ram (
    input  wire logic               clk,
    input  wire nntt_pkg::mem_ctl_t ctl,
    output nntt_pkg::track_t        rdata
);
    import nntt_pkg::*;
    track_t mem [MaxTracks];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rdata <= mem[ctl.raddr];
    end
endmodule
`default_nettype wire

>>> design/nntt_ctrl.sv
// sequencer that scans, matches, appends and compacts tracks
`default_nettype none
`include "assert_macros.svh"
module nntt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire nntt_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output nntt_pkg::out_item_t     out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire nntt_pkg::cfg_item_t cfg_data,
    output nntt_pkg::mem_ctl_t      mem_ctl,
    input  wire nntt_pkg::track_t   rdata
);
    import nntt_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MUL, S_CMP, S_DEC, S_FRAME, S_OUT} state_t;

    state_t            state_reg;
    logic [14:0]       gate_reg;
    logic [7:0]        drop_reg;
    logic [CntW-1:0]   count_reg;
    logic [15:0]       next_id_reg;
    logic [MaxTracks-1:0] matched_reg;
    logic [CntW-1:0]   idx_reg;
    logic [CntW-1:0]   keep_reg;
    logic              rd_pend_reg;
    logic [IdxW-1:0]   rd_idx_reg;
    logic signed [15:0] px_reg, py_reg;
    logic              best_ok_reg;
    logic [IdxW-1:0]   best_reg;
    logic [34:0]       best_d2_reg;
    logic [33:0]       sqx_reg, sqy_reg;
    logic [IdxW-1:0]   sq_idx_reg;
    logic [29:0]       gate2_reg;
    logic [1:0]        oc_reg;
    logic [15:0]       oid_reg;
    track_t            best_trk_reg, sq_trk_reg;
    logic              we_reg;
    logic [IdxW-1:0]   waddr_reg;
    track_t            wdata_reg;

    logic signed [17:0] dx, dy;
    logic [7:0]         lost_inc;
    logic               scan_more;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = '{outcome: oc_reg, trk_id: oid_reg, live_count: 5'(count_reg)};

    assign dx = 18'(px_reg) - (18'(rdata.cx) + 18'(rdata.vx));
    assign dy = 18'(py_reg) - (18'(rdata.cy) + 18'(rdata.vy));
    assign lost_inc = (!matched_reg[rd_idx_reg] && rdata.lost != 8'hff) ?
                      rdata.lost + 8'd1 : rdata.lost;
    assign scan_more = (idx_reg < count_reg);

    always_comb
    begin
        mem_ctl.we    = we_reg;
        mem_ctl.waddr = waddr_reg;
        mem_ctl.wdata = wdata_reg;
        mem_ctl.raddr = idx_reg[IdxW-1:0];
        if (state_reg == S_DEC)
        begin
            mem_ctl.raddr = best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            gate_reg    <= 15'd2458;
            drop_reg    <= 8'd50;
            count_reg   <= '0;
            next_id_reg <= 16'd1;
            matched_reg <= '0;
            idx_reg     <= '0;
            keep_reg    <= '0;
            rd_pend_reg <= 1'b0;
            we_reg      <= 1'b0;
            best_ok_reg <= 1'b0;
        end
        else
        begin
            we_reg <= 1'b0;
            if (cfg_valid)
            begin
                case (cfg_data.index)
                    REG_GATE: gate_reg <= cfg_data.data;
                    REG_DROP: drop_reg <= cfg_data.data[7:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        px_reg      <= in_data.pos_x;
                        py_reg      <= in_data.pos_y;
                        idx_reg     <= '0;
                        keep_reg    <= '0;
                        rd_pend_reg <= 1'b0;
                        best_ok_reg <= 1'b0;
                        gate2_reg   <= 30'(gate_reg) * 30'(gate_reg);
                        state_reg   <= (in_data.cmd == CMD_FRAME) ? S_FRAME : S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // read issued at idx, data next cycle
                    rd_pend_reg <= scan_more;
                    rd_idx_reg  <= idx_reg[IdxW-1:0];
                    if (scan_more)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (rd_pend_reg && !matched_reg[rd_idx_reg])
                    begin
                        sqx_reg    <= 34'(36'(dx) * 36'(dx));
                        sqy_reg    <= 34'(36'(dy) * 36'(dy));
                        sq_idx_reg <= rd_idx_reg;
                        sq_trk_reg <= rdata;
                        state_reg  <= S_MUL;
                    end
                    else if (!rd_pend_reg && !scan_more)
                    begin
                        state_reg <= S_CMP;
                    end
                end
                S_MUL:
                begin
                    // one compare per candidate; scan resumes afterwards
                    if (!best_ok_reg || 35'(sqx_reg) + 35'(sqy_reg) < best_d2_reg)
                    begin
                        best_ok_reg  <= 1'b1;
                        best_d2_reg  <= 35'(sqx_reg) + 35'(sqy_reg);
                        best_reg     <= sq_idx_reg;
                        best_trk_reg <= sq_trk_reg;
                    end
                    idx_reg     <= 5'(sq_idx_reg) + 1'b1;
                    rd_pend_reg <= 1'b0;
                    state_reg   <= S_SCAN;
                end
                S_CMP:
                begin
                    state_reg <= S_OUT;
                    if (best_ok_reg && best_d2_reg < 35'(gate2_reg))
                    begin
                        we_reg    <= 1'b1;
                        waddr_reg <= best_reg;
                        wdata_reg <= '{cx: px_reg, cy: py_reg,
                                       vx: 17'(px_reg) - 17'(best_trk_reg.cx),
                                       vy: 17'(py_reg) - 17'(best_trk_reg.cy),
                                       lost: 8'd0, id: best_trk_reg.id};
                        matched_reg[best_reg] <= 1'b1;
                        oc_reg  <= OUT_MATCH;
                        oid_reg <= best_trk_reg.id;
                    end
                    else if (count_reg >= CntW'(MaxTracks))
                    begin
                        oc_reg  <= OUT_DROP;
                        oid_reg <= '0;
                    end
                    else
                    begin
                        we_reg    <= 1'b1;
                        waddr_reg <= count_reg[IdxW-1:0];
                        wdata_reg <= '{cx: px_reg, cy: py_reg, vx: '0, vy: '0,
                                       lost: 8'd0, id: next_id_reg};
                        matched_reg[count_reg[IdxW-1:0]] <= 1'b1;
                        count_reg   <= count_reg + 1'b1;
                        next_id_reg <= next_id_reg + 16'd1;
                        oc_reg  <= OUT_NEW;
                        oid_reg <= next_id_reg;
                    end
                end
                S_FRAME:
                begin
                    // compaction: keep never passes idx, so writes trail reads
                    rd_pend_reg <= scan_more;
                    rd_idx_reg  <= idx_reg[IdxW-1:0];
                    if (scan_more)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (rd_pend_reg && lost_inc <= drop_reg)
                    begin
                        we_reg    <= 1'b1;
                        waddr_reg <= keep_reg[IdxW-1:0];
                        wdata_reg <= '{cx: rdata.cx, cy: rdata.cy, vx: rdata.vx,
                                       vy: rdata.vy, lost: lost_inc, id: rdata.id};
                        keep_reg  <= keep_reg + 1'b1;
                    end
                    if (!rd_pend_reg && !scan_more)
                    begin
                        count_reg   <= keep_reg;
                        matched_reg <= '0;
                        oc_reg      <= OUT_FRAME;
                        oid_reg     <= '0;
                        state_reg   <= S_OUT;
                    end
                end
                S_DEC:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= CntW'(MaxTracks))
    `ASSERT_IMPL(a_keep_le_idx, clk, rst_n, state_reg == S_FRAME, keep_reg <= idx_reg)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule
`default_nettype wire
